[sv/bdqs_pkg.sv]
// package for the bounded deque with search: codes, widths, state type
`default_nettype none

package bdqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SRCH
  } state_t;

endpackage

`default_nettype wire

[sv/bounded_deque_with_search.sv]
// bounded deque of signed 32-bit values in a ring memory, with linear search
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------------
//  in_     | in  | tvalid / tready  | tuser: req_type, tdata: value
//  out_    | out | tvalid / tready  | tdata: status, found, is_empty, count
//
//  push and pop requests update the ring memory and pointers as they are taken
//  a search reads one stored entry per cycle and stops early when the key is hit;
//  a search of an empty deque gives its result without entering the search state
//  one request is worked at a time; a new one is taken once the result register
//  is free or being drained, and a finished search waits for it while the output stalls
//  synchronous active-low reset clears state, front pointer and count, not the memory
`default_nettype none

module bounded_deque_with_search #(
  parameter int DEPTH = bdqs_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [bdqs_pkg::REQ_W-1:0]    in_tuser,   // req_type
  input  wire logic [bdqs_pkg::DATA_W-1:0]   in_tdata,   // value
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // status, found, is_empty, count, zero fill
  output logic [((bdqs_pkg::STAT_W+2+$clog2(DEPTH+1)+7)/8)*8-1:0] out_tdata
);

  localparam int IdxW  = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int SumW  = CntW + 1;
  localparam int OutW  = ((bdqs_pkg::STAT_W + 2 + CntW + 7) / 8) * 8;
  localparam int PadW  = OutW - (bdqs_pkg::STAT_W + 2 + CntW);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);

  logic [bdqs_pkg::DATA_W-1:0] mem [DEPTH];

  bdqs_pkg::state_t state_r, state_nxt;

  logic [IdxW-1:0]                front_r, front_nxt;
  logic [CntW-1:0]                occ_r, occ_nxt;
  logic [IdxW-1:0]                rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]                left_r, left_nxt;
  logic                           last_r, last_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic [bdqs_pkg::DATA_W-1:0]    key_r, key_nxt;
  logic [bdqs_pkg::DATA_W-1:0]    rd_data_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [bdqs_pkg::STAT_W-1:0]    out_status_r, out_status_nxt;
  logic                           out_found_r, out_found_nxt;
  logic                           out_empty_r, out_empty_nxt;
  logic [CntW-1:0]                out_count_r, out_count_nxt;

  logic                           slot_free;
  logic                           in_fire;
  logic                           hit;
  logic                           fin;
  logic                           done;
  logic                           issue;
  logic                           wr_en;
  logic [IdxW-1:0]                wr_addr;
  logic [SumW-1:0]                back_sum;
  logic [IdxW-1:0]                back_slot;
  logic [IdxW-1:0]                front_dec;
  logic [IdxW-1:0]                front_inc;
  logic                           is_full;
  logic                           is_zero;

  assign slot_free = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign hit       = cmp_vld_r && (rd_data_r == key_r);
  assign fin       = cmp_vld_r && (hit || last_r);
  assign done      = fin && slot_free;
  assign is_full   = (occ_r == DepthCnt);
  assign is_zero   = (occ_r == '0);

  assign back_sum  = SumW'(front_r) + SumW'(occ_r);
  assign back_slot = (back_sum >= DepthSum) ? IdxW'(back_sum - DepthSum) : IdxW'(back_sum);
  assign front_dec = (front_r == '0) ? LastIdx : front_r - 1'b1;
  assign front_inc = (front_r == LastIdx) ? '0 : front_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdqs_pkg::ST_IDLE: begin
        if (in_fire && in_tuser == bdqs_pkg::REQ_SEARCH && !is_zero) begin
          state_nxt = bdqs_pkg::ST_SRCH;
        end
      end
      bdqs_pkg::ST_SRCH: begin
        if (done) begin
          state_nxt = bdqs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bdqs_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    case (state_r)
      bdqs_pkg::ST_IDLE: begin
        in_tready = slot_free;
      end
      bdqs_pkg::ST_SRCH: begin
        issue = (left_r != '0) && !fin;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    front_nxt      = front_r;
    occ_nxt        = occ_r;
    rd_ptr_nxt     = rd_ptr_r;
    left_nxt       = left_r;
    last_nxt       = last_r;
    key_nxt        = key_r;
    cmp_vld_nxt    = issue || (fin && !slot_free);
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_empty_nxt  = out_empty_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = back_slot;

    if (issue) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
      left_nxt   = left_r - 1'b1;
      last_nxt   = (left_r == CntW'(1));
    end

    if (in_fire) begin
      out_status_nxt = bdqs_pkg::STAT_OK;
      out_found_nxt  = 1'b0;
      case (in_tuser)
        bdqs_pkg::REQ_PUSH_BACK: begin
          if (is_full) begin
            out_status_nxt = bdqs_pkg::STAT_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = back_slot;
            occ_nxt = occ_r + 1'b1;
          end
        end
        bdqs_pkg::REQ_PUSH_FRONT: begin
          if (is_full) begin
            out_status_nxt = bdqs_pkg::STAT_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            front_nxt = front_dec;
            occ_nxt   = occ_r + 1'b1;
          end
        end
        bdqs_pkg::REQ_POP_FRONT: begin
          if (is_zero) begin
            out_status_nxt = bdqs_pkg::STAT_EMPTY;
          end else begin
            front_nxt = front_inc;
            occ_nxt   = occ_r - 1'b1;
          end
        end
        bdqs_pkg::REQ_POP_BACK: begin
          if (is_zero) begin
            out_status_nxt = bdqs_pkg::STAT_EMPTY;
          end else begin
            occ_nxt = occ_r - 1'b1;
          end
        end
        bdqs_pkg::REQ_SEARCH: begin
          key_nxt    = in_tdata;
          rd_ptr_nxt = front_r;
          left_nxt   = occ_r;
        end
        default: begin
          out_status_nxt = bdqs_pkg::STAT_OK;
        end
      endcase
      out_valid_nxt = !(in_tuser == bdqs_pkg::REQ_SEARCH && !is_zero);
      out_count_nxt = occ_nxt;
      out_empty_nxt = (occ_nxt == '0);
    end

    if (state_r == bdqs_pkg::ST_SRCH && done) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = bdqs_pkg::STAT_OK;
      out_found_nxt  = hit;
      out_count_nxt  = occ_r;
      out_empty_nxt  = is_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdqs_pkg::ST_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      left_r      <= '0;
      last_r      <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      left_r      <= left_nxt;
      last_r      <= last_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_empty_r  <= out_empty_nxt;
    out_count_r  <= out_count_nxt;
  end

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PadW{1'b0}}, out_count_r, out_empty_r, out_found_r, out_status_r};

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DepthCnt)
    else $error("occupancy beyond depth");

  a_cmp_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> state_r == bdqs_pkg::ST_SRCH)
    else $error("compare pending outside search");

  a_search_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bdqs_pkg::ST_SRCH |=> occ_r == $past(occ_r) && front_r == $past(front_r))
    else $error("deque changed during search");

  a_search_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bdqs_pkg::ST_SRCH && done |=> out_valid_r && state_r == bdqs_pkg::ST_IDLE)
    else $error("finished search gave no result");

  a_search_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bdqs_pkg::ST_SRCH && left_r == '0 && !cmp_vld_r |-> 1'b0)
    else $error("search ran out of entries without a final compare");
`endif

endmodule

`default_nettype wire
